FILE: rtl/plis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plis_pkg
// Shared codes and field widths of the positional list insert/extract unit.
// ----------------------------------------------------------------------------
package plis_pkg;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FIRST = 3'd0,
        MODE_INS_LAST  = 3'd1,
        MODE_INS_AT    = 3'd2,
        MODE_EXT_FIRST = 3'd3,
        MODE_EXT_LAST  = 3'd4,
        MODE_EXT_AT    = 3'd5,
        MODE_READ_AT   = 3'd6,
        MODE_CLEAR     = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

endpackage

FILE: rtl/plis_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plis_req_if
// Request channel: valid/ready handshake with mode, position and word.
// ----------------------------------------------------------------------------
interface plis_req_if;

    logic                        valid;
    logic                        ready;
    logic [plis_pkg::MODE_W-1:0] mode;
    logic [plis_pkg::POS_W-1:0]  position;
    logic [plis_pkg::VAL_W-1:0]  value_in;

    modport source (
        output valid,
        input  ready,
        output mode,
        output position,
        output value_in
    );

    modport sink (
        input  valid,
        output ready,
        input  mode,
        input  position,
        input  value_in
    );

endinterface

FILE: rtl/plis_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plis_rsp_if
// Response channel: valid/ready handshake with status, word and length.
// ----------------------------------------------------------------------------
interface plis_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [plis_pkg::STATUS_W-1:0] status;
    logic [plis_pkg::VAL_W-1:0]    value_out;
    logic [plis_pkg::LEN_W-1:0]    length;

    modport source (
        output valid,
        input  ready,
        output status,
        output value_out,
        output length
    );

    modport sink (
        input  valid,
        output ready,
        input  status,
        input  value_out,
        input  length
    );

endinterface

FILE: rtl/plis_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plis_cell
// One storage cell of the list row: holds a word, loads a new word, takes the
// word of its left or right neighbor, and offers its word when addressed.
// ----------------------------------------------------------------------------
module plis_cell #(
    parameter int  WORD_BITS = 32,
    parameter int  AW        = 8,
    parameter int  CELL_IDX  = 0,
    parameter type cmd_t     = logic
) (
    input  logic                 clk,
    input  cmd_t                 cmd,
    input  logic [WORD_BITS-1:0] left_data,
    input  logic [WORD_BITS-1:0] right_data,
    output logic [WORD_BITS-1:0] data,
    output logic [WORD_BITS-1:0] rd_data
);

    localparam logic [AW-1:0] MY_IDX = AW'(CELL_IDX);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;

    always_comb
    begin
        if (cmd.wr_en && (cmd.wr_idx == MY_IDX))
        begin
            data_next = cmd.wr_data;
        end
        else if (cmd.shr_en && (MY_IDX >= cmd.shr_lo) && (MY_IDX <= cmd.shr_hi))
        begin
            data_next = left_data;
        end
        else if (cmd.shl_en && (MY_IDX >= cmd.shl_lo) && (MY_IDX <= cmd.shl_hi))
        begin
            data_next = right_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (cmd.rd_en && (cmd.rd_idx == MY_IDX)) ? data_reg : '0;

endmodule

FILE: rtl/positional_list_insert_extract_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_extract_unit
// Ordered list of up to DEPTH words held in a row of cells between a front and
// an end index; inserts and extracts at the front, the back or a position, reads
// at a position, clears all, and shifts neighbors by one cell in the same cycle.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   mode, position, value_in
//   rsp      out  valid/ready   status, value_out, length
//
// one item per cycle unless a held response stops req: cells do every shift in one step
// the response for an item is registered and shows in the cycle after accept
// req.ready is high while the response register is empty or being taken
// rsp.ready low holds the response and stops new items after one
// reset clears the indices and the response valid; cell contents need none
// ----------------------------------------------------------------------------
module positional_list_insert_extract_unit #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    plis_req_if.sink   req,
    plis_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(DEPTH + 1);
    localparam int AW    = ((IDX_W > plis_pkg::POS_W) ? IDX_W : plis_pkg::POS_W) + 1;

    localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);
    localparam logic [AW-1:0] ONE_A   = AW'(1);
    localparam logic [AW-1:0] TWO_A   = AW'(2);

    typedef struct packed {
        logic                 wr_en;
        logic [AW-1:0]        wr_idx;
        logic [WORD_BITS-1:0] wr_data;
        logic                 shr_en;
        logic [AW-1:0]        shr_lo;
        logic [AW-1:0]        shr_hi;
        logic                 shl_en;
        logic [AW-1:0]        shl_lo;
        logic [AW-1:0]        shl_hi;
        logic                 rd_en;
        logic [AW-1:0]        rd_idx;
    } cell_cmd_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_PUT_FIRST,
        ACT_PUT_LAST,
        ACT_PUT_MID,
        ACT_TAKE_FIRST,
        ACT_TAKE_LAST,
        ACT_TAKE_MID,
        ACT_READ,
        ACT_CLEAR
    } action_t;

    logic [IDX_W-1:0] front_reg;
    logic [IDX_W-1:0] front_next;
    logic [IDX_W-1:0] end_reg;
    logic [IDX_W-1:0] end_next;

    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    logic [plis_pkg::STATUS_W-1:0]   status_reg;
    logic [plis_pkg::STATUS_W-1:0]   status_next;
    logic [plis_pkg::VAL_W-1:0]      value_reg;
    logic [plis_pkg::VAL_W-1:0]      value_next;
    logic [plis_pkg::LEN_W-1:0]      length_reg;
    logic [plis_pkg::LEN_W-1:0]      length_next;

    logic                 accept;
    plis_pkg::mode_t      mode;
    plis_pkg::status_t    status;
    action_t              action;
    logic [AW-1:0]        fa;
    logic [AW-1:0]        ea;
    logic [AW-1:0]        pa;
    logic [AW-1:0]        len;
    logic [AW-1:0]        fa_next;
    logic [AW-1:0]        ea_next;
    logic [AW-1:0]        len_next;
    logic                 full;
    logic                 room_left;
    logic [WORD_BITS-1:0] word_in;
    logic [WORD_BITS-1:0] rd_or;
    logic [plis_pkg::VAL_W-1:0] rd_word;
    cell_cmd_t            cmd_raw;
    cell_cmd_t            cmd;

    logic [WORD_BITS-1:0] cell_data [DEPTH];
    logic [WORD_BITS-1:0] cell_rd   [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign mode      = plis_pkg::mode_t'(req.mode);

    assign fa  = AW'(front_reg);
    assign ea  = AW'(end_reg);
    assign pa  = AW'(req.position);
    assign len = ea - fa;

    assign full      = (len >= DEPTH_A);
    assign room_left = (ea == DEPTH_A) && (fa != '0);

    generate
        if (WORD_BITS <= plis_pkg::VAL_W)
        begin : g_win_narrow
            assign word_in = req.value_in[WORD_BITS-1:0];
        end
        else
        begin : g_win_wide
            assign word_in = {{(WORD_BITS - plis_pkg::VAL_W){1'b0}}, req.value_in};
        end

        if (WORD_BITS >= plis_pkg::VAL_W)
        begin : g_wout_wide
            assign rd_word = rd_or[plis_pkg::VAL_W-1:0];
        end
        else
        begin : g_wout_narrow
            assign rd_word = {{(plis_pkg::VAL_W - WORD_BITS){1'b0}}, rd_or};
        end
    endgenerate

    // error check and action select
    always_comb
    begin
        status = plis_pkg::STATUS_OK;
        action = ACT_NONE;
        case (mode)
            plis_pkg::MODE_INS_FIRST:
            begin
                if (full) status = plis_pkg::STATUS_FULL;
                else      action = ACT_PUT_FIRST;
            end
            plis_pkg::MODE_INS_LAST:
            begin
                if (full) status = plis_pkg::STATUS_FULL;
                else      action = ACT_PUT_LAST;
            end
            plis_pkg::MODE_INS_AT:
            begin
                if (full)            status = plis_pkg::STATUS_FULL;
                else if (pa > len)   status = plis_pkg::STATUS_RANGE;
                else if (pa == '0)   action = ACT_PUT_FIRST;
                else if (pa == len)  action = ACT_PUT_LAST;
                else                 action = ACT_PUT_MID;
            end
            plis_pkg::MODE_EXT_FIRST:
            begin
                if (len == '0) status = plis_pkg::STATUS_EMPTY;
                else           action = ACT_TAKE_FIRST;
            end
            plis_pkg::MODE_EXT_LAST:
            begin
                if (len == '0) status = plis_pkg::STATUS_EMPTY;
                else           action = ACT_TAKE_LAST;
            end
            plis_pkg::MODE_EXT_AT:
            begin
                if (pa >= len)             status = plis_pkg::STATUS_RANGE;
                else if (pa == '0)         action = ACT_TAKE_FIRST;
                else if (pa + ONE_A == len) action = ACT_TAKE_LAST;
                else                       action = ACT_TAKE_MID;
            end
            plis_pkg::MODE_READ_AT:
            begin
                if (pa >= len) status = plis_pkg::STATUS_RANGE;
                else           action = ACT_READ;
            end
            plis_pkg::MODE_CLEAR:
            begin
                action = ACT_CLEAR;
            end
            default:
            begin
                action = ACT_NONE;
            end
        endcase
    end

    // index update and cell command
    always_comb
    begin
        fa_next         = fa;
        ea_next         = ea;
        cmd_raw         = '0;
        cmd_raw.wr_data = word_in;
        case (action)
            ACT_PUT_FIRST:
            begin
                cmd_raw.wr_en = 1'b1;
                if (len == '0)
                begin
                    ea_next        = ea + ONE_A;
                    cmd_raw.wr_idx = fa;
                end
                else if (fa != '0)
                begin
                    fa_next        = fa - ONE_A;
                    cmd_raw.wr_idx = fa - ONE_A;
                end
                else
                begin
                    cmd_raw.shr_en = 1'b1;
                    cmd_raw.shr_lo = fa + ONE_A;
                    cmd_raw.shr_hi = ea;
                    ea_next        = ea + ONE_A;
                    cmd_raw.wr_idx = fa;
                end
            end
            ACT_PUT_LAST:
            begin
                cmd_raw.wr_en = 1'b1;
                if (room_left)
                begin
                    cmd_raw.shl_en = 1'b1;
                    cmd_raw.shl_lo = fa - ONE_A;
                    cmd_raw.shl_hi = ea - TWO_A;
                    fa_next        = fa - ONE_A;
                    cmd_raw.wr_idx = ea - ONE_A;
                end
                else
                begin
                    ea_next        = ea + ONE_A;
                    cmd_raw.wr_idx = ea;
                end
            end
            ACT_PUT_MID:
            begin
                cmd_raw.wr_en = 1'b1;
                if (room_left)
                begin
                    cmd_raw.shl_en = 1'b1;
                    cmd_raw.shl_lo = fa - ONE_A;
                    cmd_raw.shl_hi = fa + pa - TWO_A;
                    fa_next        = fa - ONE_A;
                    cmd_raw.wr_idx = fa + pa - ONE_A;
                end
                else
                begin
                    cmd_raw.shr_en = 1'b1;
                    cmd_raw.shr_lo = fa + pa + ONE_A;
                    cmd_raw.shr_hi = ea;
                    ea_next        = ea + ONE_A;
                    cmd_raw.wr_idx = fa + pa;
                end
            end
            ACT_TAKE_FIRST:
            begin
                cmd_raw.rd_en  = 1'b1;
                cmd_raw.rd_idx = fa;
                if (len != ONE_A) fa_next = fa + ONE_A;
                else              ea_next = ea - ONE_A;
            end
            ACT_TAKE_LAST:
            begin
                cmd_raw.rd_en  = 1'b1;
                cmd_raw.rd_idx = ea - ONE_A;
                ea_next        = ea - ONE_A;
            end
            ACT_TAKE_MID:
            begin
                cmd_raw.rd_en  = 1'b1;
                cmd_raw.rd_idx = fa + pa;
                cmd_raw.shl_en = 1'b1;
                cmd_raw.shl_lo = fa + pa;
                cmd_raw.shl_hi = ea - TWO_A;
                ea_next        = ea - ONE_A;
            end
            ACT_READ:
            begin
                cmd_raw.rd_en  = 1'b1;
                cmd_raw.rd_idx = fa + pa;
            end
            ACT_CLEAR:
            begin
                fa_next = '0;
                ea_next = '0;
            end
            default:
            begin
                fa_next = fa;
            end
        endcase
    end

    always_comb
    begin
        cmd        = cmd_raw;
        cmd.wr_en  = cmd_raw.wr_en && accept;
        cmd.shr_en = cmd_raw.shr_en && accept;
        cmd.shl_en = cmd_raw.shl_en && accept;
    end

    // row of cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [WORD_BITS-1:0] left_w;
            logic [WORD_BITS-1:0] right_w;

            if (gi == 0)
            begin : g_left_edge
                assign left_w = '0;
            end
            else
            begin : g_left_link
                assign left_w = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_right_edge
                assign right_w = '0;
            end
            else
            begin : g_right_link
                assign right_w = cell_data[gi+1];
            end

            plis_cell #(
                .WORD_BITS (WORD_BITS),
                .AW        (AW),
                .CELL_IDX  (gi),
                .cmd_t     (cell_cmd_t)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .left_data  (left_w),
                .right_data (right_w),
                .data       (cell_data[gi]),
                .rd_data    (cell_rd[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    assign front_next  = accept ? fa_next[IDX_W-1:0] : front_reg;
    assign end_next    = accept ? ea_next[IDX_W-1:0] : end_reg;
    assign len_next    = ea_next - fa_next;

    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp.ready);
    assign status_next    = accept ? status : status_reg;
    assign value_next     = accept ? (cmd_raw.rd_en ? rd_word : '0) : value_reg;
    assign length_next    = accept ? len_next[plis_pkg::LEN_W-1:0] : length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            end_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            end_reg       <= end_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        length_reg <= length_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.value_out = value_reg;
    assign rsp.length    = length_reg;

    // live window stays ordered and inside the row
    assert property (@(posedge clk) disable iff (!rst_n)
        (front_reg <= end_reg) && (AW'(end_reg) <= DEPTH_A))
    else $error("list indices out of order or beyond the row");

    // a failed request carries no word
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg != plis_pkg::STATUS_OK)) |-> (value_reg == '0))
    else $error("word returned with an error status");

    // an error leaves the indices alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (status != plis_pkg::STATUS_OK))
        |=> ((front_reg == $past(front_reg)) && (end_reg == $past(end_reg))))
    else $error("indices changed on a failed request");

    // clear empties the list
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == plis_pkg::MODE_CLEAR))
        |=> ((front_reg == '0) && (end_reg == '0) && (length_reg == '0)))
    else $error("clear left words behind");

endmodule

FILE: tb/sv/positional_list_insert_extract_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_extract_unit_tb
// Drives requests over the request channel and checks every response field
// against a queue-based list predictor or, for typed rows, the table. A short
// table covers the empty and range codes, list edges and single-word corner
// cases. A fill to full depth follows, then random request streams that walk
// the list between empty and full. Handshake gaps on both channels vary by
// phase, with one long response hold-off and drain pauses between phases.
// ----------------------------------------------------------------------------
module positional_list_insert_extract_unit_tb;

    localparam int DEPTH        = 64;
    localparam int WORD_BITS    = 32;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 600;
    localparam int SETTLE       = 4;

    localparam int MODE_W = plis_pkg::MODE_W;
    localparam int POS_W  = plis_pkg::POS_W;
    localparam int VAL_W  = plis_pkg::VAL_W;
    localparam int LEN_W  = plis_pkg::LEN_W;

    typedef struct {
        plis_pkg::mode_t    mode;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   value;
    } request_t;

    typedef struct {
        plis_pkg::status_t  status;
        logic [VAL_W-1:0]   word;
        logic [LEN_W-1:0]   length;
    } list_reply_t;

    typedef struct {
        plis_pkg::mode_t    mode;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   value;
        bit                 typed;
        plis_pkg::status_t  status;
        logic [VAL_W-1:0]   word;
        logic [LEN_W-1:0]   length;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    plis_req_if req ();
    plis_rsp_if rsp ();

    positional_list_insert_extract_unit #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #2 clk = ~clk;

    // predictor state: the live words, front first
    logic [VAL_W-1:0] list_words [$];
    list_reply_t      pending_replies [$];
    list_reply_t      no_reply;

    int  send_idle_pct   = 33;
    int  recv_idle_pct   = 86;
    bit  hold_rsp        = 1'b0;
    bit  growing         = 1'b1;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  mismatch_count  = 0;
    int  deepest_length  = 0;
    int  quiet_cycles    = 0;
    int  status_seen [4] = '{0, 0, 0, 0};

    plis_pkg::mode_t insert_modes  [3] = '{plis_pkg::MODE_INS_FIRST,
                                           plis_pkg::MODE_INS_LAST,
                                           plis_pkg::MODE_INS_AT};
    plis_pkg::mode_t extract_modes [3] = '{plis_pkg::MODE_EXT_FIRST,
                                           plis_pkg::MODE_EXT_LAST,
                                           plis_pkg::MODE_EXT_AT};

    directed_row_t directed_rows [25] = '{
        '{plis_pkg::MODE_EXT_FIRST, 7'd0,   32'h0000_0000,
          1'b1, plis_pkg::STATUS_EMPTY, 32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_EXT_LAST,  7'd0,   32'h0000_0000,
          1'b1, plis_pkg::STATUS_EMPTY, 32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_EXT_AT,    7'd0,   32'h0000_0000,
          1'b1, plis_pkg::STATUS_RANGE, 32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_READ_AT,   7'd0,   32'h0000_0000,
          1'b1, plis_pkg::STATUS_RANGE, 32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_INS_AT,    7'd1,   32'hDEAD_BEEF,
          1'b1, plis_pkg::STATUS_RANGE, 32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_INS_AT,    7'd0,   32'hFFFF_FFFF,
          1'b1, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd1},
        '{plis_pkg::MODE_READ_AT,   7'd0,   32'h0000_0000,
          1'b1, plis_pkg::STATUS_OK,    32'hFFFF_FFFF, 7'd1},
        '{plis_pkg::MODE_EXT_FIRST, 7'd0,   32'h0000_0000,
          1'b1, plis_pkg::STATUS_OK,    32'hFFFF_FFFF, 7'd0},
        '{plis_pkg::MODE_INS_FIRST, 7'd0,   32'h0000_0000,
          1'b1, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd1},
        '{plis_pkg::MODE_INS_LAST,  7'd0,   32'hA5A5_A5A5,
          1'b0, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_INS_AT,    7'd1,   32'h5A5A_5A5A,
          1'b0, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_INS_AT,    7'd3,   32'h1234_5678,
          1'b0, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_INS_AT,    7'd5,   32'h0BAD_F00D,
          1'b1, plis_pkg::STATUS_RANGE, 32'h0000_0000, 7'd4},
        '{plis_pkg::MODE_READ_AT,   7'd127, 32'h0000_0000,
          1'b1, plis_pkg::STATUS_RANGE, 32'h0000_0000, 7'd4},
        '{plis_pkg::MODE_READ_AT,   7'd3,   32'h0000_0000,
          1'b0, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_EXT_AT,    7'd1,   32'h0000_0000,
          1'b0, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_EXT_AT,    7'd2,   32'h0000_0000,
          1'b0, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_EXT_AT,    7'd0,   32'h0000_0000,
          1'b0, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_INS_FIRST, 7'd0,   32'h8000_0001,
          1'b0, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_EXT_LAST,  7'd0,   32'h0000_0000,
          1'b0, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_CLEAR,     7'd0,   32'h0000_0000,
          1'b1, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_CLEAR,     7'd0,   32'h0000_0000,
          1'b1, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd0},
        '{plis_pkg::MODE_INS_LAST,  7'd0,   32'h0000_0001,
          1'b1, plis_pkg::STATUS_OK,    32'h0000_0000, 7'd1},
        '{plis_pkg::MODE_EXT_LAST,  7'd0,   32'h0000_0000,
          1'b1, plis_pkg::STATUS_OK,    32'h0000_0001, 7'd0},
        '{plis_pkg::MODE_INS_AT,    7'd127, 32'h0000_0000,
          1'b1, plis_pkg::STATUS_RANGE, 32'h0000_0000, 7'd0}
    };

    function automatic list_reply_t serve_request(input request_t r);
        list_reply_t reply;
        int          count;
        count        = list_words.size();
        reply.status = plis_pkg::STATUS_OK;
        reply.word   = '0;
        case (r.mode)
            plis_pkg::MODE_INS_FIRST:
                if (count >= DEPTH) reply.status = plis_pkg::STATUS_FULL;
                else list_words.push_front(r.value);
            plis_pkg::MODE_INS_LAST:
                if (count >= DEPTH) reply.status = plis_pkg::STATUS_FULL;
                else list_words.push_back(r.value);
            plis_pkg::MODE_INS_AT:
                if (count >= DEPTH) reply.status = plis_pkg::STATUS_FULL;
                else if (r.position > count) reply.status = plis_pkg::STATUS_RANGE;
                else if (r.position == count) list_words.push_back(r.value);
                else list_words.insert(r.position, r.value);
            plis_pkg::MODE_EXT_FIRST:
                if (count == 0) reply.status = plis_pkg::STATUS_EMPTY;
                else reply.word = list_words.pop_front();
            plis_pkg::MODE_EXT_LAST:
                if (count == 0) reply.status = plis_pkg::STATUS_EMPTY;
                else reply.word = list_words.pop_back();
            plis_pkg::MODE_EXT_AT:
                if (r.position >= count) reply.status = plis_pkg::STATUS_RANGE;
                else
                begin
                    reply.word = list_words[r.position];
                    list_words.delete(r.position);
                end
            plis_pkg::MODE_READ_AT:
                if (r.position >= count) reply.status = plis_pkg::STATUS_RANGE;
                else reply.word = list_words[r.position];
            default:
                list_words.delete();
        endcase
        reply.length = LEN_W'(list_words.size());
        if (list_words.size() > deepest_length) deepest_length = list_words.size();
        return reply;
    endfunction

    // walks the list toward full or empty, with a little noise on top
    function automatic request_t random_request();
        request_t r;
        int       count;
        count = list_words.size();
        if (count == DEPTH) growing = 1'b0;
        else if (count == 0) growing = 1'b1;
        else if ($urandom_range(99) < 3) growing = !growing;
        r.value = $urandom();
        case ($urandom_range(15))
            0: r.value = '0;
            1: r.value = '1;
            default: ;
        endcase
        r.position = (count == 0) ? '0 : POS_W'($urandom_range(count - 1));
        if ($urandom_range(299) == 0)
            r.mode = plis_pkg::MODE_CLEAR;
        else if ($urandom_range(99) < 6)
        begin
            r.mode     = plis_pkg::mode_t'(MODE_W'($urandom()));
            r.position = POS_W'($urandom());
        end
        else if ($urandom_range(99) < 15)
            r.mode = plis_pkg::MODE_READ_AT;
        else if ($urandom_range(99) < (growing ? 70 : 30))
        begin
            r.mode     = insert_modes[$urandom_range(2)];
            r.position = POS_W'($urandom_range(count));
        end
        else
            r.mode = extract_modes[$urandom_range(2)];
        if ($urandom_range(99) < 4) r.position = POS_W'($urandom());
        return r;
    endfunction

    task automatic send(input request_t r, input bit typed, input list_reply_t typed_reply);
        list_reply_t reply;
        req.valid    <= 1'b1;
        req.mode     <= r.mode;
        req.position <= r.position;
        req.value_in <= r.value;
        @(posedge clk);
        while (req.ready !== 1'b1) @(posedge clk);
        reply = serve_request(r);
        items_sent++;
        status_seen[reply.status]++;
        pending_replies.push_back(typed ? typed_reply : reply);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic pause_until_drained();
        req.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        request_t r;
        repeat (count)
        begin
            r = random_request();
            send(r, 1'b0, no_reply);
        end
    endtask

    // fill to full depth, hit the full checks, then force moves toward the front
    task automatic run_full_list_sequence();
        request_t r;
        r.mode     = plis_pkg::MODE_CLEAR;
        r.position = '0;
        r.value    = '0;
        send(r, 1'b0, no_reply);
        r.mode = plis_pkg::MODE_INS_LAST;
        repeat (DEPTH)
        begin
            r.value = $urandom();
            send(r, 1'b0, no_reply);
        end
        r.mode = plis_pkg::MODE_INS_FIRST;
        send(r, 1'b0, no_reply);
        r.mode     = plis_pkg::MODE_INS_AT;
        r.position = '1;
        send(r, 1'b0, no_reply);
        r.mode = plis_pkg::MODE_EXT_FIRST;
        repeat (3) send(r, 1'b0, no_reply);
        r.mode  = plis_pkg::MODE_INS_LAST;
        r.value = $urandom();
        send(r, 1'b0, no_reply);
        r.mode     = plis_pkg::MODE_INS_AT;
        r.position = 7'd40;
        r.value    = $urandom();
        send(r, 1'b0, no_reply);
        r.mode  = plis_pkg::MODE_INS_FIRST;
        r.value = $urandom();
        send(r, 1'b0, no_reply);
        r.mode     = plis_pkg::MODE_READ_AT;
        r.position = 7'd63;
        send(r, 1'b0, no_reply);
        r.mode = plis_pkg::MODE_EXT_AT;
        send(r, 1'b0, no_reply);
        r.position = 7'd20;
        send(r, 1'b0, no_reply);
    endtask

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        list_reply_t want;
        if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            results_checked++;
            if (pending_replies.size() == 0)
            begin
                $error("unexpected item: status %0d value_out %h length %0d",
                       rsp.status, rsp.value_out, rsp.length);
                mismatch_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.value_out !== want.word)
                begin
                    $error("value_out: expected %h, got %h", want.word, rsp.value_out);
                    mismatch_count++;
                end
                if (rsp.length !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length, rsp.length);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid === 1'b1 && req.ready === 1'b1) ||
            (rsp.valid === 1'b1 && rsp.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        request_t      r;
        directed_row_t row;
        list_reply_t   typed_reply;
        rst_n        = 1'b0;
        req.valid    = 1'b0;
        req.mode     = plis_pkg::MODE_CLEAR;
        req.position = '0;
        req.value_in = '0;
        no_reply     = '{plis_pkg::STATUS_OK, '0, '0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row         = directed_rows[i];
            r           = '{row.mode, row.position, row.value};
            typed_reply = '{row.status, row.word, row.length};
            send(r, row.typed, typed_reply);
        end
        run_full_list_sequence();
        run_random(RANDOM_ITEMS);
        pause_until_drained();

        send_idle_pct = 86;
        recv_idle_pct = 33;
        run_random(RANDOM_ITEMS / 2);
        hold_rsp = 1'b1;
        run_random(RANDOM_ITEMS / 2);
        pause_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_ITEMS);
        pause_until_drained();
        repeat (SETTLE) @(posedge clk);

        $display("requests: %0d (ok %0d, full %0d, out of range %0d, empty %0d)",
                 items_sent, status_seen[plis_pkg::STATUS_OK],
                 status_seen[plis_pkg::STATUS_FULL],
                 status_seen[plis_pkg::STATUS_RANGE],
                 status_seen[plis_pkg::STATUS_EMPTY]);
        $display("deepest list %0d, responses compared: %0d, mismatches: %0d",
                 deepest_length, results_checked, mismatch_count);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
